### design/wls_pkg.sv
// Shared types, constants and fixed-point helpers for the 1-D wave leapfrog stencil.
// Used by the plane store, the update pipeline and the top level. No dependencies.
package wls_pkg;

   localparam int PORT_W    = 32;
   localparam int ACC_W     = 52;
   localparam int WIDE_W    = 17;
   localparam int A2_W      = 16;
   localparam int GLEN_W    = 14;
   localparam int COEF_W    = 18;
   localparam int INDEX_W   = 13;
   localparam int STEPS_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SQUARED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_LENGTH   = 1'd1;

   localparam logic [A2_W-1:0]   A2_RESET   = 16'd5898;
   localparam logic [GLEN_W-1:0] GLEN_RESET = 14'd5000;
   localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(2 * (65536 - 5898));

   typedef enum logic [1:0] {
      ACT_LOAD,
      ACT_INIT,
      ACT_ADVANCE,
      ACT_READ
   } action_type;

   typedef struct packed {
      logic signed [PORT_W-1:0] re;
      logic signed [PORT_W-1:0] im;
   } cplx_type;

   // Coefficients held constant for the duration of a sweep.
   typedef struct packed {
      logic              init;
      logic [A2_W-1:0]   a2;
      logic [COEF_W-1:0] coef;
   } coef_type;

   function automatic logic signed [ACC_W-1:0] sx_acc(input logic signed [PORT_W-1:0] x);
      return ACC_W'(x);
   endfunction

   // Clamps a wide value to the signed range of fbits bits.
   function automatic logic signed [PORT_W-1:0] sat_field(
      input logic signed [ACC_W-1:0] x,
      input int unsigned             fbits
   );
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = $signed((ACC_W'(1) << (fbits - 1)) - ACC_W'(1));
      lo = ~hi;
      if (x > hi) begin
         return hi[PORT_W-1:0];
      end else if (x < lo) begin
         return lo[PORT_W-1:0];
      end
      return x[PORT_W-1:0];
   endfunction

endpackage

### design/wave_1d_leapfrog_stencil.sv
// Top level of the 1-D wave leapfrog stencil: command sequencer, sweep window
// and register port. Uses wls_pkg, wls_plane_store and wls_update_pipe.
//
// An item is taken when start is high and busy is low. Every item gives one
// result, shown on the rsp_ ports for a single cycle with rsp_valid high; the
// receiver cannot hold it off.
// A load, or a read with an index at or beyond the grid length, answers in the
// cycle after it is taken. A read in range answers from the read state, which
// captures the registered plane output. Initialize runs one sweep and advance
// runs one sweep per step. A sweep over L points issues L + 1 memory reads,
// and the update pipeline must drain before the next sweep may read the
// planes again. An advance of zero steps answers in the cycle after it is
// taken. The single read port of each plane, one point per cycle, sets the
// sweep rate.
// The block is busy from the cycle after a sweep or read is taken until its
// result appears, and it may take the next item in the cycle the result shows.
// Reset returns the sequencer to idle and the registers to their reset
// values; the plane memories are not cleared and must be loaded before use.
// The user must write registers through csr_ only while the block is idle; the block itself does not enforce this.
module wave_1d_leapfrog_stencil
   import wls_pkg::*;
#(
   parameter int GRID_DEPTH = 8192,
   parameter int FIELD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic [INDEX_W-1:0]       req_index,
   input  logic signed [PORT_W-1:0] req_disp_re,
   input  logic signed [PORT_W-1:0] req_disp_im,
   input  logic signed [PORT_W-1:0] req_vel_re,
   input  logic signed [PORT_W-1:0] req_vel_im,
   input  logic [STEPS_W-1:0]       req_steps,
   output logic                     rsp_valid,
   output logic signed [PORT_W-1:0] rsp_field_re,
   output logic signed [PORT_W-1:0] rsp_field_im,
   output logic                     rsp_status,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [A2_W-1:0]          csr_wdata
);

   localparam int AW     = $clog2(GRID_DEPTH);
   localparam int LEN_W  = $clog2(GRID_DEPTH + 1);
   localparam int WORD_W = 2 * FIELD_BITS;
   localparam logic [LEN_W-1:0] LEN_RESET =
      LEN_W'((int'(GLEN_RESET) > GRID_DEPTH) ? GRID_DEPTH : int'(GLEN_RESET));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // Register port.
   logic [A2_W-1:0]   a2_ff;
   logic [COEF_W-1:0] coef_ff;
   logic [COEF_W-1:0] coef_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [WIDE_W-1:0] glen_wide;

   always_comb begin
      coef_in   = {17'(17'd65536 - {1'b0, csr_wdata}), 1'b0};
      glen_wide = WIDE_W'(csr_wdata[GLEN_W-1:0]);
      len_in    = (glen_wide > WIDE_W'(GRID_DEPTH)) ? LEN_W'(GRID_DEPTH)
                                                    : glen_wide[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_ff   <= A2_RESET;
         coef_ff <= COEF_RESET;
         len_ff  <= LEN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ALPHA_SQUARED: begin
               a2_ff   <= csr_wdata;
               coef_ff <= coef_in;
            end
            REG_GRID_LENGTH: begin
               len_ff <= len_in;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   state_type            state_ff;
   logic                 init_ff;
   logic [STEPS_W-1:0]   steps_ff;
   logic [LEN_W-1:0]     tok_ptr_ff;
   logic                 rsp_valid_ff;
   logic signed [PORT_W-1:0] rsp_re_ff;
   logic signed [PORT_W-1:0] rsp_im_ff;
   logic                 rsp_status_ff;

   logic                 accept;
   logic [WIDE_W-1:0]    idx_wide;
   logic                 idx_inside;
   logic                 load_wr;
   logic                 tok_issue;
   logic                 pipe_busy;
   action_type           action;

   // Sweep pipeline.
   logic                 iss_vld_ff;
   logic                 iss_real_ff;
   logic                 iss_first_ff;
   logic [LEN_W-1:0]     iss_k_ff;
   logic [LEN_W-1:0]     km1;
   cplx_type             win_left_ff;
   cplx_type             win_mid_ff;
   cplx_type             win_prv_ff;
   cplx_type             e1_d0_ff;
   cplx_type             oth_d0_ff;
   logic signed [PORT_W:0] nsum_re_ff;
   logic signed [PORT_W:0] nsum_im_ff;
   logic [3:0]           vld_ff;
   logic [AW-1:0]        addr_ff [4];
   cplx_type             cur_e;
   cplx_type             prv_e;
   cplx_type             right_e;
   coef_type             coef_bus;
   logic signed [PORT_W-1:0] main_re;
   logic signed [PORT_W-1:0] main_im;
   logic signed [PORT_W-1:0] aux_re;
   logic signed [PORT_W-1:0] aux_im;

   // Memory ports.
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_W-1:0]    cur_wdata;
   logic [WORD_W-1:0]    prv_wdata;
   logic [WORD_W-1:0]    cur_rdata;
   logic [WORD_W-1:0]    prv_rdata;
   logic signed [PORT_W-1:0] ld_dre;
   logic signed [PORT_W-1:0] ld_dim;
   logic signed [PORT_W-1:0] ld_vre;
   logic signed [PORT_W-1:0] ld_vim;

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      accept     = start && !busy;
      action     = action_type'(req_action);
      idx_wide   = WIDE_W'(req_index);
      idx_inside = idx_wide < WIDE_W'(len_ff);
      load_wr    = accept && (action == ACT_LOAD) && idx_inside;
      tok_issue  = (state_ff == ST_SWEEP);
      pipe_busy  = iss_vld_ff || (|vld_ff);

      ld_dre = sat_field(sx_acc(req_disp_re), FIELD_BITS);
      ld_dim = sat_field(sx_acc(req_disp_im), FIELD_BITS);
      ld_vre = sat_field(sx_acc(req_vel_re), FIELD_BITS);
      ld_vim = sat_field(sx_acc(req_vel_im), FIELD_BITS);

      rd_addr = (state_ff == ST_IDLE) ? idx_wide[AW-1:0] : tok_ptr_ff[AW-1:0];
      wr_en   = load_wr || vld_ff[3];
      if (load_wr) begin
         wr_addr   = idx_wide[AW-1:0];
         cur_wdata = {ld_dim[FIELD_BITS-1:0], ld_dre[FIELD_BITS-1:0]};
         prv_wdata = {ld_vim[FIELD_BITS-1:0], ld_vre[FIELD_BITS-1:0]};
      end else begin
         wr_addr   = addr_ff[3];
         cur_wdata = {main_im[FIELD_BITS-1:0], main_re[FIELD_BITS-1:0]};
         prv_wdata = {aux_im[FIELD_BITS-1:0], aux_re[FIELD_BITS-1:0]};
      end

      cur_e.re = PORT_W'($signed(cur_rdata[FIELD_BITS-1:0]));
      cur_e.im = PORT_W'($signed(cur_rdata[WORD_W-1:FIELD_BITS]));
      prv_e.re = PORT_W'($signed(prv_rdata[FIELD_BITS-1:0]));
      prv_e.im = PORT_W'($signed(prv_rdata[WORD_W-1:FIELD_BITS]));
      right_e  = iss_real_ff ? cur_e : '0;
      km1      = iss_k_ff - LEN_W'(1);

      coef_bus.init = init_ff;
      coef_bus.a2   = a2_ff;
      coef_bus.coef = coef_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_re_ff     <= '0;
                  rsp_im_ff     <= '0;
                  rsp_status_ff <= 1'b0;
                  tok_ptr_ff    <= '0;
                  case (action)
                     ACT_LOAD: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= !idx_inside;
                     end
                     ACT_INIT: begin
                        init_ff  <= 1'b1;
                        steps_ff <= STEPS_W'(1);
                        state_ff <= ST_SWEEP;
                     end
                     ACT_ADVANCE: begin
                        init_ff  <= 1'b0;
                        steps_ff <= req_steps;
                        if (req_steps == '0) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SWEEP;
                        end
                     end
                     default: begin
                        if (idx_inside) begin
                           state_ff <= ST_READ;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= 1'b1;
                        end
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_re_ff    <= cur_e.re;
               rsp_im_ff    <= cur_e.im;
               state_ff     <= ST_IDLE;
            end
            ST_SWEEP: begin
               if (tok_ptr_ff == len_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  tok_ptr_ff <= tok_ptr_ff + LEN_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  if (steps_ff > STEPS_W'(1)) begin
                     steps_ff   <= steps_ff - STEPS_W'(1);
                     tok_ptr_ff <= '0;
                     state_ff   <= ST_SWEEP;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The window holds the old values of the left point, the point being
   // updated and its previous-plane entry while the right neighbor arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         iss_vld_ff <= tok_issue;
         vld_ff     <= {vld_ff[2:0], iss_vld_ff && !iss_first_ff};
      end
      iss_k_ff     <= tok_ptr_ff;
      iss_real_ff  <= tok_ptr_ff < len_ff;
      iss_first_ff <= tok_ptr_ff == '0;
      if (iss_vld_ff) begin
         win_left_ff <= iss_first_ff ? '0 : win_mid_ff;
         win_mid_ff  <= right_e;
         win_prv_ff  <= prv_e;
      end
      e1_d0_ff   <= win_mid_ff;
      oth_d0_ff  <= win_prv_ff;
      nsum_re_ff <= (PORT_W + 1)'(win_left_ff.re) + (PORT_W + 1)'(right_e.re);
      nsum_im_ff <= (PORT_W + 1)'(win_left_ff.im) + (PORT_W + 1)'(right_e.im);
      addr_ff[0] <= km1[AW-1:0];
      addr_ff[1] <= addr_ff[0];
      addr_ff[2] <= addr_ff[1];
      addr_ff[3] <= addr_ff[2];
   end

   wls_plane_store #(
      .GRID_DEPTH (GRID_DEPTH),
      .FIELD_BITS (FIELD_BITS)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .cur_wdata (cur_wdata),
      .prv_wdata (prv_wdata),
      .cur_rdata (cur_rdata),
      .prv_rdata (prv_rdata)
   );

   wls_update_pipe #(
      .FIELD_BITS (FIELD_BITS)
   ) u_pipe_re (
      .clock    (clock),
      .cfg      (coef_bus),
      .e1_in    (e1_d0_ff.re),
      .other_in (oth_d0_ff.re),
      .nsum_in  (nsum_re_ff),
      .main_out (main_re),
      .aux_out  (aux_re)
   );

   wls_update_pipe #(
      .FIELD_BITS (FIELD_BITS)
   ) u_pipe_im (
      .clock    (clock),
      .cfg      (coef_bus),
      .e1_in    (e1_d0_ff.im),
      .other_in (oth_d0_ff.im),
      .nsum_in  (nsum_im_ff),
      .main_out (main_im),
      .aux_out  (aux_im)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_field_re = rsp_re_ff;
   assign rsp_field_im = rsp_im_ff;
   assign rsp_status   = rsp_status_ff;

   a_sweep_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("Sweep write-back outside of a sweep.");

   a_drain_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && pipe_busy) |=> (state_ff == ST_DRAIN))
      else $error("Drain left while the update pipeline still held points.");

   a_token_bound: assert property (@(posedge clock) disable iff (reset)
      iss_vld_ff |-> (iss_k_ff <= len_ff))
      else $error("Sweep token beyond the grid length.");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(load_wr && vld_ff[3]))
      else $error("Load item and sweep write-back collided.");

   a_busy_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("Block became busy without taking an item.");

endmodule

### design/wls_plane_store.sv
// Two synchronous grid memories: the current plane and the previous plane.
// One write port and one registered read port each. Uses wls_pkg.
module wls_plane_store
   import wls_pkg::*;
#(
   parameter int GRID_DEPTH = 8192,
   parameter int FIELD_BITS = 32
) (
   input  logic                          clock,
   input  logic [$clog2(GRID_DEPTH)-1:0] rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(GRID_DEPTH)-1:0] wr_addr,
   input  logic [2*FIELD_BITS-1:0]       cur_wdata,
   input  logic [2*FIELD_BITS-1:0]       prv_wdata,
   output logic [2*FIELD_BITS-1:0]       cur_rdata,
   output logic [2*FIELD_BITS-1:0]       prv_rdata
);

   localparam int WORD_W = 2 * FIELD_BITS;

   logic [WORD_W-1:0] cur_mem [GRID_DEPTH];
   logic [WORD_W-1:0] prv_mem [GRID_DEPTH];
   logic [WORD_W-1:0] cur_rdata_ff;
   logic [WORD_W-1:0] prv_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cur_mem[wr_addr] <= cur_wdata;
         prv_mem[wr_addr] <= prv_wdata;
      end
      cur_rdata_ff <= cur_mem[rd_addr];
      prv_rdata_ff <= prv_mem[rd_addr];
   end

   assign cur_rdata = cur_rdata_ff;
   assign prv_rdata = prv_rdata_ff;

endmodule

### design/wls_update_pipe.sv
// Three-stage update for one component of a grid point: products, rounding with
// saturation, then the second output plane. Uses wls_pkg.
module wls_update_pipe
   import wls_pkg::*;
#(
   parameter int FIELD_BITS = 32
) (
   input  logic                     clock,
   input  coef_type                 cfg,
   input  logic signed [PORT_W-1:0] e1_in,
   input  logic signed [PORT_W-1:0] other_in,
   input  logic signed [PORT_W:0]   nsum_in,
   output logic signed [PORT_W-1:0] main_out,
   output logic signed [PORT_W-1:0] aux_out
);

   localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] RND17 = ACC_W'(65536);

   logic signed [ACC_W-1:0]  prod_c_ff;
   logic signed [ACC_W-1:0]  prod_a_ff;
   logic signed [PORT_W-1:0] oth_a_ff;
   logic signed [PORT_W-1:0] e1_a_ff;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  r16;
   logic signed [ACC_W-1:0]  r17;
   logic signed [ACC_W-1:0]  val;
   logic signed [PORT_W-1:0] main_b_in;
   logic signed [PORT_W-1:0] main_b_ff;
   logic signed [PORT_W-1:0] oth_b_ff;
   logic signed [PORT_W-1:0] e1_b_ff;
   logic signed [PORT_W-1:0] aux_c_in;
   logic signed [PORT_W-1:0] main_c_ff;
   logic signed [PORT_W-1:0] aux_c_ff;

   always_comb begin
      acc       = prod_c_ff + prod_a_ff;
      r16       = (acc + RND16) >>> 16;
      r17       = (acc + RND17) >>> 17;
      val       = cfg.init ? (sx_acc(oth_a_ff) + r17) : (r16 - sx_acc(oth_a_ff));
      main_b_in = sat_field(val, FIELD_BITS);
      aux_c_in  = cfg.init ?
                  sat_field(sx_acc(main_b_ff) - (sx_acc(oth_b_ff) <<< 1), FIELD_BITS) :
                  e1_b_ff;
   end

   always_ff @(posedge clock) begin
      prod_c_ff <= ACC_W'(e1_in) * ACC_W'($signed({1'b0, cfg.coef}));
      prod_a_ff <= ACC_W'(nsum_in) * ACC_W'($signed({1'b0, cfg.a2}));
      oth_a_ff  <= other_in;
      e1_a_ff   <= e1_in;
      main_b_ff <= main_b_in;
      oth_b_ff  <= oth_a_ff;
      e1_b_ff   <= e1_a_ff;
      main_c_ff <= main_b_ff;
      aux_c_ff  <= aux_c_in;
   end

   assign main_out = main_c_ff;
   assign aux_out  = aux_c_ff;

endmodule
